// File: rtl/crd_pkg.sv
package crd_pkg;

   // Report buffer geometry
   localparam int MAX_REPORT_BYTES = 23;
   localparam int CNT_W            = $clog2(MAX_REPORT_BYTES + 1);
   localparam int IDX_W            = $clog2(MAX_REPORT_BYTES);

   // Queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Register port
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam int REG_IDX_W = 1;
   localparam logic [REG_IDX_W-1:0] REG_EXTENSION_KIND = 1'd0;
   localparam logic [REG_IDX_W-1:0] REG_WANT_ACCEL     = 1'd1;

   // Report constants
   localparam logic [7:0] REPORT_HEADER = 8'ha1;
   localparam logic [7:0] TYPE_BTN_21   = 8'h21;
   localparam logic [7:0] TYPE_BTN_22   = 8'h22;
   localparam logic [7:0] TYPE_BTN_30   = 8'h30;
   localparam logic [7:0] TYPE_ACC      = 8'h31;
   localparam logic [7:0] TYPE_EXT      = 8'h32;
   localparam logic [7:0] TYPE_ACC_IRX  = 8'h33;
   localparam logic [7:0] TYPE_ACC_EXT  = 8'h35;
   localparam logic [7:0] TYPE_IRB_EXT  = 8'h36;
   localparam logic [7:0] TYPE_ALL      = 8'h37;
   localparam logic [7:0] EXT_KEY       = 8'h17;
   localparam logic [9:0] IR_NONE       = 10'h3ff;
   localparam logic [1:0] EXT_NUNCHUK   = 2'd2;

   // Result step numbering, in emission order
   localparam int STEP_W = 4;
   localparam int NUM_STEPS = 13;
   localparam logic [STEP_W-1:0] STEP_BUTTONS = 4'd0;
   localparam logic [STEP_W-1:0] STEP_ACCEL0  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_ACCEL2  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_IR0     = 4'd4;
   localparam logic [STEP_W-1:0] STEP_IR3     = 4'd7;
   localparam logic [STEP_W-1:0] STEP_JOY0    = 4'd8;
   localparam logic [STEP_W-1:0] STEP_JOY1    = 4'd9;
   localparam logic [STEP_W-1:0] STEP_NUN0    = 4'd10;
   localparam logic [STEP_W-1:0] STEP_NUN2    = 4'd12;

   typedef enum logic [2:0] {
      KIND_BUTTONS = 3'd0,
      KIND_ACCEL   = 3'd1,
      KIND_IR      = 3'd2,
      KIND_JOY     = 3'd3,
      KIND_NUNCHUK = 3'd4
   } crd_kind_type;

   typedef enum logic [2:0] {
      LAYOUT_BUTTONS,
      LAYOUT_ACCEL,
      LAYOUT_EXT,
      LAYOUT_ACCEL_IRX,
      LAYOUT_ACCEL_EXT,
      LAYOUT_IRB_EXT,
      LAYOUT_ALL
   } crd_layout_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       end_of_packet;
   } crd_req_type;

   typedef struct packed {
      logic [2:0]  item_kind;
      logic [1:0]  item_index;
      logic [12:0] first_value;
      logic [9:0]  second_value;
      logic        point_valid;
      logic        last_of_report;
   } crd_rsp_type;

   typedef logic [MAX_REPORT_BYTES-1:0][7:0] crd_record_type;

   // One classified report waiting for decode
   typedef struct packed {
      crd_layout_type layout;
      crd_record_type bytes;
   } crd_entry_type;

   typedef struct packed {
      logic [1:0] extension_kind;
      logic       want_accel;
   } crd_cfg_type;

   // Extension byte unscrambling
   function automatic logic [7:0] ext_decode(input logic [7:0] b);
      ext_decode = (b ^ EXT_KEY) + EXT_KEY;
   endfunction

endpackage

// File: rtl/crd_front.sv
module crd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  crd_pkg::crd_req_type   req_data,
   input  logic                   q_full,
   output logic                   push,
   output crd_pkg::crd_entry_type push_entry
);

   logic [crd_pkg::CNT_W-1:0] count_ff, count_in;
   logic [7:0]                buf_ff [crd_pkg::MAX_REPORT_BYTES];
   logic                      accept;
   logic                      has_room;
   logic [crd_pkg::CNT_W-1:0] len;
   crd_pkg::crd_record_type   rec;
   crd_pkg::crd_layout_type   layout;
   logic                      known;
   logic                      hdr_ok;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign has_room  = count_ff < crd_pkg::CNT_W'(crd_pkg::MAX_REPORT_BYTES);
   assign len       = has_room ? count_ff + 1'b1 : count_ff;

   // Byte count: restarts after the end mark
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_data.end_of_packet) begin
            count_in = '0;
         end else if (has_room) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Buffer write; bytes past the end are dropped
   always_ff @(posedge clock) begin
      if (accept && has_room) begin
         buf_ff[count_ff[crd_pkg::IDX_W-1:0]] <= req_data.packet_byte;
      end
   end

   // Full report image with the current byte merged in, unreceived bytes zero
   always_comb begin
      for (int i = 0; i < crd_pkg::MAX_REPORT_BYTES; i++) begin
         if (crd_pkg::CNT_W'(i) < len) begin
            if (has_room && crd_pkg::CNT_W'(i) == count_ff) begin
               rec[i] = req_data.packet_byte;
            end else begin
               rec[i] = buf_ff[i];
            end
         end else begin
            rec[i] = 8'h00;
         end
      end
   end

   // Classify by header and type byte
   always_comb begin
      known  = 1'b1;
      layout = crd_pkg::LAYOUT_BUTTONS;
      case (rec[1]) inside
         crd_pkg::TYPE_BTN_21, crd_pkg::TYPE_BTN_22, crd_pkg::TYPE_BTN_30: begin
            layout = crd_pkg::LAYOUT_BUTTONS;
         end
         crd_pkg::TYPE_ACC:     layout = crd_pkg::LAYOUT_ACCEL;
         crd_pkg::TYPE_EXT:     layout = crd_pkg::LAYOUT_EXT;
         crd_pkg::TYPE_ACC_IRX: layout = crd_pkg::LAYOUT_ACCEL_IRX;
         crd_pkg::TYPE_ACC_EXT: layout = crd_pkg::LAYOUT_ACCEL_EXT;
         crd_pkg::TYPE_IRB_EXT: layout = crd_pkg::LAYOUT_IRB_EXT;
         crd_pkg::TYPE_ALL:     layout = crd_pkg::LAYOUT_ALL;
         default:               known  = 1'b0;
      endcase
   end

   assign hdr_ok = (len >= crd_pkg::CNT_W'(2)) && (rec[0] == crd_pkg::REPORT_HEADER);
   assign push   = accept && req_data.end_of_packet && hdr_ok && known;

   assign push_entry.layout = layout;
   assign push_entry.bytes  = rec;

endmodule

// File: rtl/crd_queue.sv
module crd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  crd_pkg::crd_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   not_empty,
   output crd_pkg::crd_entry_type head
);

   crd_pkg::crd_entry_type      mem_ff [crd_pkg::Q_DEPTH];
   logic [crd_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [crd_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [crd_pkg::Q_CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = cnt_ff == crd_pkg::Q_CNT_W'(crd_pkg::Q_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == crd_pkg::Q_PTR_W'(crd_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == crd_pkg::Q_PTR_W'(crd_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/crd_back.sv
module crd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  crd_pkg::crd_cfg_type   cfg,
   input  logic                   not_empty,
   input  crd_pkg::crd_entry_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output crd_pkg::crd_rsp_type   rsp_data
);

   logic [crd_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   crd_pkg::crd_rsp_type       rsp_data_ff, rsp_data_in;

   crd_pkg::crd_record_type    rec;
   logic                       has_accel, has_irx, has_irb, has_ext, ext_on;
   logic [crd_pkg::IDX_W-1:0]  ir_off, ext_off;
   logic [crd_pkg::NUM_STEPS-1:0] mask;
   logic [crd_pkg::STEP_W-1:0] nxt;
   logic                       found;
   logic                       load;
   logic [1:0]                 sub;
   logic [7:0]                 b0, b1, d5, dsel;
   logic [crd_pkg::IDX_W-1:0]  dsel_idx;
   logic [crd_pkg::IDX_W-1:0]  o, x_idx, y_idx, m_idx;
   logic [7:0]                 m;
   logic [9:0]                 ir_x, ir_y;
   logic [1:0]                 ext_btn;
   crd_pkg::crd_rsp_type       cur;

   assign rec = head.bytes;
   assign b0  = rec[2];
   assign b1  = rec[3];

   // Layout flags and byte offsets
   always_comb begin
      has_accel = 1'b0;
      has_irx   = 1'b0;
      has_irb   = 1'b0;
      has_ext   = 1'b0;
      ir_off    = crd_pkg::IDX_W'(7);
      ext_off   = '0;
      case (head.layout)
         crd_pkg::LAYOUT_BUTTONS: ;
         crd_pkg::LAYOUT_ACCEL:   has_accel = 1'b1;
         crd_pkg::LAYOUT_EXT: begin
            has_ext = 1'b1;
            ext_off = crd_pkg::IDX_W'(4);
         end
         crd_pkg::LAYOUT_ACCEL_IRX: begin
            has_accel = 1'b1;
            has_irx   = 1'b1;
         end
         crd_pkg::LAYOUT_ACCEL_EXT: begin
            has_accel = 1'b1;
            has_ext   = 1'b1;
            ext_off   = crd_pkg::IDX_W'(7);
         end
         crd_pkg::LAYOUT_IRB_EXT: begin
            has_irb = 1'b1;
            ir_off  = crd_pkg::IDX_W'(4);
            has_ext = 1'b1;
            ext_off = crd_pkg::IDX_W'(14);
         end
         crd_pkg::LAYOUT_ALL: begin
            has_accel = 1'b1;
            has_irb   = 1'b1;
            has_ext   = 1'b1;
            ext_off   = crd_pkg::IDX_W'(17);
         end
         default: ;
      endcase
   end

   assign ext_on = has_ext && (cfg.extension_kind == crd_pkg::EXT_NUNCHUK);

   // Which result steps this report produces
   always_comb begin
      mask = '0;
      mask[crd_pkg::STEP_BUTTONS] = 1'b1;
      for (int i = 0; i < crd_pkg::NUM_STEPS; i++) begin
         if (crd_pkg::STEP_W'(i) >= crd_pkg::STEP_ACCEL0 &&
             crd_pkg::STEP_W'(i) <= crd_pkg::STEP_ACCEL2) begin
            mask[i] = has_accel;
         end else if (crd_pkg::STEP_W'(i) >= crd_pkg::STEP_IR0 &&
                      crd_pkg::STEP_W'(i) <= crd_pkg::STEP_IR3) begin
            mask[i] = has_irx || has_irb;
         end else if (crd_pkg::STEP_W'(i) >= crd_pkg::STEP_JOY0 &&
                      crd_pkg::STEP_W'(i) <= crd_pkg::STEP_JOY1) begin
            mask[i] = ext_on;
         end else if (crd_pkg::STEP_W'(i) >= crd_pkg::STEP_NUN0 &&
                      crd_pkg::STEP_W'(i) <= crd_pkg::STEP_NUN2) begin
            mask[i] = ext_on && cfg.want_accel;
         end
      end
   end

   // Next enabled step after the current one
   always_comb begin
      nxt   = crd_pkg::STEP_BUTTONS;
      found = 1'b0;
      for (int i = crd_pkg::NUM_STEPS - 1; i >= 0; i--) begin
         if (mask[i] && crd_pkg::STEP_W'(i) > step_ff) begin
            nxt   = crd_pkg::STEP_W'(i);
            found = 1'b1;
         end
      end
   end

   // Extension bytes: byte 5 plus one selected by step
   assign d5 = crd_pkg::ext_decode(rec[ext_off + crd_pkg::IDX_W'(5)]);
   always_comb begin
      if (step_ff == crd_pkg::STEP_JOY0 || step_ff == crd_pkg::STEP_JOY1) begin
         dsel_idx = ext_off + crd_pkg::IDX_W'(step_ff - crd_pkg::STEP_JOY0);
      end else begin
         dsel_idx = ext_off + crd_pkg::IDX_W'(2) +
                    crd_pkg::IDX_W'(step_ff - crd_pkg::STEP_NUN0);
      end
   end
   assign dsel = crd_pkg::ext_decode(rec[dsel_idx]);

   // IR point byte positions
   always_comb begin
      sub = 2'(step_ff - crd_pkg::STEP_IR0);
      if (has_irx) begin
         o     = ir_off + crd_pkg::IDX_W'({sub, 1'b0}) + crd_pkg::IDX_W'(sub);
         m_idx = o + crd_pkg::IDX_W'(2);
         x_idx = o;
         y_idx = o + crd_pkg::IDX_W'(1);
      end else begin
         o     = ir_off + (sub[1] ? crd_pkg::IDX_W'(5) : crd_pkg::IDX_W'(0));
         m_idx = o + crd_pkg::IDX_W'(2);
         x_idx = sub[0] ? o + crd_pkg::IDX_W'(3) : o;
         y_idx = sub[0] ? o + crd_pkg::IDX_W'(4) : o + crd_pkg::IDX_W'(1);
      end
   end
   assign m = rec[m_idx];
   always_comb begin
      if (has_irb && sub[0]) begin
         ir_x = {m[1:0], rec[x_idx]};
         ir_y = {m[3:2], rec[y_idx]};
      end else begin
         ir_x = {m[5:4], rec[x_idx]};
         ir_y = {m[7:6], rec[y_idx]};
      end
   end

   assign ext_btn = ext_on ? ~d5[1:0] : 2'b00;

   // Field values of the current step
   always_comb begin
      cur.item_kind      = crd_pkg::KIND_BUTTONS;
      cur.item_index     = 2'd0;
      cur.first_value    = {ext_btn, b0[4:0], b1[7], b1[4:0]};
      cur.second_value   = 10'd0;
      cur.point_valid    = 1'b1;
      cur.last_of_report = !found;
      case (step_ff) inside
         [crd_pkg::STEP_ACCEL0:crd_pkg::STEP_ACCEL2]: begin
            cur.item_kind  = crd_pkg::KIND_ACCEL;
            cur.item_index = 2'(step_ff - crd_pkg::STEP_ACCEL0);
            case (cur.item_index)
               2'd0:    cur.first_value = {4'd0, rec[4], b0[6]};
               2'd1:    cur.first_value = {4'd0, rec[5], b1[5]};
               default: cur.first_value = {4'd0, rec[6], b1[6]};
            endcase
         end
         [crd_pkg::STEP_IR0:crd_pkg::STEP_IR3]: begin
            cur.item_kind    = crd_pkg::KIND_IR;
            cur.item_index   = sub;
            cur.first_value  = {3'd0, ir_x};
            cur.second_value = ir_y;
            cur.point_valid  = (ir_x != crd_pkg::IR_NONE) && (ir_y != crd_pkg::IR_NONE);
         end
         [crd_pkg::STEP_JOY0:crd_pkg::STEP_JOY1]: begin
            cur.item_kind   = crd_pkg::KIND_JOY;
            cur.item_index  = 2'(step_ff - crd_pkg::STEP_JOY0);
            cur.first_value = {5'd0, dsel};
         end
         [crd_pkg::STEP_NUN0:crd_pkg::STEP_NUN2]: begin
            cur.item_kind  = crd_pkg::KIND_NUNCHUK;
            cur.item_index = 2'(step_ff - crd_pkg::STEP_NUN0);
            case (cur.item_index)
               2'd0:    cur.first_value = {3'd0, dsel, d5[3:2]};
               2'd1:    cur.first_value = {3'd0, dsel, d5[5:4]};
               default: cur.first_value = {3'd0, dsel, d5[7:6]};
            endcase
         end
         default: ;
      endcase
   end

   // Output register and step sequencing
   assign load = not_empty && (!rsp_valid_ff || rsp_ready);
   assign pop  = load && !found;

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = cur;
         step_in      = found ? nxt : crd_pkg::STEP_BUTTONS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= crd_pkg::STEP_BUTTONS;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/controller_report_decoder_core.sv
// Channel   Ports                         Moves
// req       req_valid/ready/data          one report byte and end mark per transfer
// rsp       rsp_valid/ready/data          one decoded report field per transfer
// csr       psel/penable/pwrite/paddr/... register writes and reads, no wait states
//
// A byte is taken every cycle while the report queue (two classified reports) has room.
// Results leave one per cycle while rsp_ready is high; a report gives 1 to 13 of them, stepped by the back end.
// A report's first result passes through the queue entry and then the output register before rsp_valid rises.
// Reset (synchronous) empties the queue and the output register, zeroes the byte count and clears the config registers.
// An output stall backs up into the queue, and req_ready drops only when it is full.
module controller_report_decoder_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  crd_pkg::crd_req_type        req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output crd_pkg::crd_rsp_type        rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [crd_pkg::PADDR_W-1:0] paddr,
   input  logic [crd_pkg::PDATA_W-1:0] pwdata,
   output logic [crd_pkg::PDATA_W-1:0] prdata,
   output logic                        pready
);

   crd_pkg::crd_cfg_type   cfg_ff, cfg_in;
   logic                   wr_en;
   logic [crd_pkg::REG_IDX_W-1:0] reg_idx;
   logic                   q_full, q_push, q_pop, q_not_empty;
   crd_pkg::crd_entry_type q_in, q_head;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[crd_pkg::PADDR_W-1:2];

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            crd_pkg::REG_EXTENSION_KIND: cfg_in.extension_kind = pwdata[1:0];
            crd_pkg::REG_WANT_ACCEL:     cfg_in.want_accel     = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads
   always_comb begin
      case (reg_idx)
         crd_pkg::REG_EXTENSION_KIND: prdata = {30'd0, cfg_ff.extension_kind};
         crd_pkg::REG_WANT_ACCEL:     prdata = {31'd0, cfg_ff.want_accel};
         default:                     prdata = '0;
      endcase
   end

   crd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_full     (q_full),
      .push       (q_push),
      .push_entry (q_in)
   );

   crd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   crd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .not_empty (q_not_empty),
      .head      (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: verif/tb_top.sv
module tb_top;

   localparam int  SETTLE_CYCLES = 30;
   localparam int  TOTAL_ITEMS   = 120;
   localparam logic [7:0] TYPE_STATUS = 8'h20;

   typedef enum int {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES,
      FILL_MIXED
   } fill_mode_type;

   // DUT connections, inputs known from time zero
   logic                         clock          = 1'b0;
   logic                         reset          = 1'b1;
   logic                         req_valid      = 1'b0;
   logic                         req_ready;
   crd_pkg::crd_req_type         req_data       = '0;
   logic                         rsp_valid;
   logic                         rsp_ready      = 1'b0;
   crd_pkg::crd_rsp_type         rsp_data;
   logic                         psel           = 1'b0;
   logic                         penable        = 1'b0;
   logic                         pwrite         = 1'b0;
   logic [crd_pkg::PADDR_W-1:0]  paddr          = '0;
   logic [crd_pkg::PDATA_W-1:0]  pwdata         = '0;
   logic [crd_pkg::PDATA_W-1:0]  prdata;
   logic                         pready;

   // Predictor state: report bytes, count and register copies
   logic [7:0]                   rpt_buf [crd_pkg::MAX_REPORT_BYTES];
   int unsigned                  rpt_count      = 0;
   logic [1:0]                   cfg_ext_kind   = 2'd0;
   logic                         cfg_want_accel = 1'b0;
   crd_pkg::crd_rsp_type         field_expect_q [$];

   // Traffic control
   bit                           tx_steady      = 1'b0;
   bit                           rsp_steady     = 1'b0;
   int                           rsp_hold_req   = 0;
   int                           rsp_hold_left  = 0;
   int                           rsp_stall_left = 0;
   int                           rsp_pick;
   int unsigned                  bytes_sent     = 0;
   bit                           mismatch_seen  = 1'b0;
   crd_pkg::crd_rsp_type         field_got;

   controller_report_decoder_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [7:0] rpt_byte(input int unsigned idx, input int unsigned len);
      // bytes never received read as zero
      if (idx >= len || idx >= crd_pkg::MAX_REPORT_BYTES) return 8'h00;
      return rpt_buf[idx];
   endfunction

   function automatic crd_pkg::crd_rsp_type make_field(input logic [2:0] kind,
                                                       input logic [1:0] idx,
                                                       input logic [12:0] first,
                                                       input logic [9:0] second,
                                                       input logic valid);
      crd_pkg::crd_rsp_type f;
      f.item_kind      = kind;
      f.item_index     = idx;
      f.first_value    = first;
      f.second_value   = second;
      f.point_valid    = valid;
      f.last_of_report = 1'b0;
      return f;
   endfunction

   function automatic crd_pkg::crd_rsp_type make_ir_point(input logic [1:0] idx,
                                                          input logic [9:0] x,
                                                          input logic [9:0] y);
      return make_field(crd_pkg::KIND_IR, idx, {3'b000, x}, y,
                        (x != crd_pkg::IR_NONE) && (y != crd_pkg::IR_NONE));
   endfunction

   task automatic decode_report(input int unsigned len);
      crd_pkg::crd_rsp_type fields [$];
      crd_pkg::crd_rsp_type tail_field;
      logic [7:0]  rtype, b0, b1, m;
      logic [12:0] buttons;
      logic [7:0]  d [6];
      bit          has_acc, has_ext, has_irx, has_irb;
      int unsigned ir_off, ext_off, o, i;

      has_acc = 1'b0;
      has_ext = 1'b0;
      has_irx = 1'b0;
      has_irb = 1'b0;
      ir_off  = 0;
      ext_off = 0;
      if (len < 2 || rpt_byte(0, len) != crd_pkg::REPORT_HEADER) return;
      rtype = rpt_byte(1, len);
      case (rtype)
         crd_pkg::TYPE_BTN_21, crd_pkg::TYPE_BTN_22, crd_pkg::TYPE_BTN_30: ;
         crd_pkg::TYPE_ACC: has_acc = 1'b1;
         crd_pkg::TYPE_EXT: begin
            has_ext = 1'b1; ext_off = 4;
         end
         crd_pkg::TYPE_ACC_IRX: begin
            has_acc = 1'b1; has_irx = 1'b1; ir_off = 7;
         end
         crd_pkg::TYPE_ACC_EXT: begin
            has_acc = 1'b1; has_ext = 1'b1; ext_off = 7;
         end
         crd_pkg::TYPE_IRB_EXT: begin
            has_irb = 1'b1; ir_off = 4; has_ext = 1'b1; ext_off = 14;
         end
         crd_pkg::TYPE_ALL: begin
            has_acc = 1'b1; has_irb = 1'b1; ir_off = 7; has_ext = 1'b1; ext_off = 17;
         end
         default: return;
      endcase

      // button word, extension bytes unscrambled
      b0 = rpt_byte(2, len);
      b1 = rpt_byte(3, len);
      buttons = {2'b00, b0[4:0], b1[7], b1[4:0]};
      for (i = 0; i < 6; i++)
         d[i] = (rpt_byte(ext_off + i, len) ^ crd_pkg::EXT_KEY) + crd_pkg::EXT_KEY;
      has_ext = has_ext && (cfg_ext_kind == crd_pkg::EXT_NUNCHUK);
      if (has_ext)
         buttons[12:11] = ~d[5][1:0];
      fields.push_back(make_field(crd_pkg::KIND_BUTTONS, 2'd0, buttons, 10'd0, 1'b1));

      if (has_acc) begin
         fields.push_back(make_field(crd_pkg::KIND_ACCEL, 2'd0,
                                     {4'd0, rpt_byte(4, len), b0[6]}, 10'd0, 1'b1));
         fields.push_back(make_field(crd_pkg::KIND_ACCEL, 2'd1,
                                     {4'd0, rpt_byte(5, len), b1[5]}, 10'd0, 1'b1));
         fields.push_back(make_field(crd_pkg::KIND_ACCEL, 2'd2,
                                     {4'd0, rpt_byte(6, len), b1[6]}, 10'd0, 1'b1));
      end

      // extended IR: three bytes per point
      if (has_irx) begin
         for (i = 0; i < 4; i++) begin
            o = ir_off + i * 3;
            m = rpt_byte(o + 2, len);
            fields.push_back(make_ir_point(i[1:0], {m[5:4], rpt_byte(o, len)},
                                           {m[7:6], rpt_byte(o + 1, len)}));
         end
      end

      // basic IR: five bytes per pair of points
      if (has_irb) begin
         for (i = 0; i < 2; i++) begin
            o = ir_off + i * 5;
            m = rpt_byte(o + 2, len);
            fields.push_back(make_ir_point(2'(i * 2), {m[5:4], rpt_byte(o, len)},
                                           {m[7:6], rpt_byte(o + 1, len)}));
            fields.push_back(make_ir_point(2'(i * 2 + 1), {m[1:0], rpt_byte(o + 3, len)},
                                           {m[3:2], rpt_byte(o + 4, len)}));
         end
      end

      if (has_ext) begin
         fields.push_back(make_field(crd_pkg::KIND_JOY, 2'd0, {5'd0, d[0]}, 10'd0, 1'b1));
         fields.push_back(make_field(crd_pkg::KIND_JOY, 2'd1, {5'd0, d[1]}, 10'd0, 1'b1));
         if (cfg_want_accel) begin
            fields.push_back(make_field(crd_pkg::KIND_NUNCHUK, 2'd0,
                                        {3'd0, d[2], d[5][3:2]}, 10'd0, 1'b1));
            fields.push_back(make_field(crd_pkg::KIND_NUNCHUK, 2'd1,
                                        {3'd0, d[3], d[5][5:4]}, 10'd0, 1'b1));
            fields.push_back(make_field(crd_pkg::KIND_NUNCHUK, 2'd2,
                                        {3'd0, d[4], d[5][7:6]}, 10'd0, 1'b1));
         end
      end

      tail_field = fields.pop_back();
      tail_field.last_of_report = 1'b1;
      fields.push_back(tail_field);
      foreach (fields[k])
         field_expect_q.push_back(fields[k]);
   endtask

   task automatic collect_byte(input crd_pkg::crd_req_type it);
      int unsigned len;
      // bytes past the buffer size are dropped
      if (rpt_count < crd_pkg::MAX_REPORT_BYTES) begin
         rpt_buf[rpt_count] = it.packet_byte;
         rpt_count++;
      end
      if (it.end_of_packet) begin
         len = rpt_count;
         rpt_count = 0;
         decode_report(len);
      end
   endtask

   // ---------------------------------------------------------------- result side

   // ready: mostly high, short stalls, now and then a long one
   always @(posedge clock) begin
      if (rsp_hold_req > 0) begin
         rsp_hold_left = rsp_hold_req;
         rsp_hold_req  = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left--;
      end else if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left--;
      end else if (rsp_steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_pick = $urandom_range(0, 99);
         if (rsp_pick < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            rsp_stall_left = (rsp_pick < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
         end
      end
   end

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_seen = 1'b1;
      end
   endtask

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (field_expect_q.size() == 0) begin
            $error("result transfer with nothing expected: kind %0d first %0d",
                   rsp_data.item_kind, rsp_data.first_value);
            mismatch_seen = 1'b1;
         end else begin
            field_got = field_expect_q.pop_front();
            check_field("item_kind", field_got.item_kind, rsp_data.item_kind);
            check_field("item_index", field_got.item_index, rsp_data.item_index);
            check_field("first_value", field_got.first_value, rsp_data.first_value);
            check_field("second_value", field_got.second_value, rsp_data.second_value);
            check_field("point_valid", field_got.point_valid, rsp_data.point_valid);
            check_field("last_of_report", field_got.last_of_report, rsp_data.last_of_report);
         end
      end
   end

   // ---------------------------------------------------------------- request side

   function automatic int pick_tx_gap();
      int r;
      if (tx_steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // one byte transfer; valid stays up when the next byte follows at once
   task automatic send_byte(input crd_pkg::crd_req_type it);
      int gap;
      gap = pick_tx_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      collect_byte(it);
   endtask

   task automatic req_stop();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_report(input logic [7:0] hdr, input logic [7:0] rtype,
                              input int unsigned len, input fill_mode_type fill);
      crd_pkg::crd_req_type it;
      logic [7:0]  b;
      int unsigned i;
      for (i = 0; i < len; i++) begin
         if (i == 0) begin
            b = hdr;
         end else if (i == 1) begin
            b = rtype;
         end else begin
            case (fill)
               FILL_ZERO: b = 8'h00;
               FILL_ONES: b = 8'hff;
               FILL_MIXED: b = ($urandom_range(0, 1) == 1) ? 8'hff : 8'($urandom);
               default: b = 8'($urandom);
            endcase
         end
         it.packet_byte   = b;
         it.end_of_packet = (i == len - 1);
         send_byte(it);
      end
   endtask

   function automatic logic [7:0] layout_type(input int unsigned n);
      case (n)
         0: return crd_pkg::TYPE_BTN_21;
         1: return crd_pkg::TYPE_BTN_22;
         2: return crd_pkg::TYPE_BTN_30;
         3: return crd_pkg::TYPE_ACC;
         4: return crd_pkg::TYPE_EXT;
         5: return crd_pkg::TYPE_ACC_IRX;
         6: return crd_pkg::TYPE_ACC_EXT;
         7: return crd_pkg::TYPE_IRB_EXT;
         default: return crd_pkg::TYPE_ALL;
      endcase
   endfunction

   // ---------------------------------------------------------------- register port

   task automatic csr_write(input logic [crd_pkg::REG_IDX_W-1:0] idx,
                            input logic [crd_pkg::PDATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      // register takes the value at this edge
      if (idx == crd_pkg::REG_EXTENSION_KIND)
         cfg_ext_kind = data[1:0];
      else
         cfg_want_accel = data[0];
      psel    <= 1'b0;
      penable <= 1'b0;
      // bus idle before the next setup
      @(posedge clock);
   endtask

   // drop valid, wait for all results, then let the back end go quiet
   task automatic settle();
      req_stop();
      while (field_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [1:0] ext_kind, input logic want);
      settle();
      csr_write(crd_pkg::REG_EXTENSION_KIND, {30'd0, ext_kind});
      csr_write(crd_pkg::REG_WANT_ACCEL, {31'd0, want});
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_report_layouts();
      set_config(crd_pkg::EXT_NUNCHUK, 1'b1);
      // each layout but TYPE_ALL, cut short where its fields end or earlier
      send_report(crd_pkg::REPORT_HEADER, crd_pkg::TYPE_BTN_21, 4, FILL_RANDOM);
      send_report(crd_pkg::REPORT_HEADER, crd_pkg::TYPE_BTN_22, 3, FILL_RANDOM);
      send_report(crd_pkg::REPORT_HEADER, crd_pkg::TYPE_BTN_30, 4, FILL_RANDOM);
      send_report(crd_pkg::REPORT_HEADER, crd_pkg::TYPE_ACC, 7, FILL_RANDOM);
      send_report(crd_pkg::REPORT_HEADER, crd_pkg::TYPE_EXT, 6, FILL_RANDOM);
      send_report(crd_pkg::REPORT_HEADER, crd_pkg::TYPE_ACC_IRX, 9, FILL_RANDOM);
      send_report(crd_pkg::REPORT_HEADER, crd_pkg::TYPE_ACC_EXT, 9, FILL_RANDOM);
      send_report(crd_pkg::REPORT_HEADER, crd_pkg::TYPE_IRB_EXT, 10, FILL_RANDOM);
   endtask

   task automatic test_field_extremes();
      // all-ones overlong report: invalid IR points, top values, last byte dropped
      send_report(crd_pkg::REPORT_HEADER, crd_pkg::TYPE_ALL,
                  crd_pkg::MAX_REPORT_BYTES + 1, FILL_ONES);
   endtask

   task automatic test_malformed_reports();
      // too short, bad header, status and unknown types
      send_report(crd_pkg::REPORT_HEADER, 8'h00, 1, FILL_RANDOM);
      send_report(crd_pkg::REPORT_HEADER ^ 8'h01, crd_pkg::TYPE_ALL, 2, FILL_RANDOM);
      send_report(crd_pkg::REPORT_HEADER, TYPE_STATUS, 3, FILL_RANDOM);
      send_report(crd_pkg::REPORT_HEADER, 8'hff, 3, FILL_RANDOM);
      // short report reads zeros past its end
      send_report(crd_pkg::REPORT_HEADER, crd_pkg::TYPE_ALL, 2, FILL_RANDOM);
   endtask

   task automatic test_config_sweep();
      int unsigned k;
      for (k = 0; k < 4; k++) begin
         set_config(k[1:0], k[0]);
         send_report(crd_pkg::REPORT_HEADER, crd_pkg::TYPE_EXT, 3, FILL_RANDOM);
      end
   endtask

   task automatic test_output_backpressure();
      int unsigned n;
      set_config(crd_pkg::EXT_NUNCHUK, 1'b1);
      // receiver holds off long enough for the report queue to fill
      rsp_hold_req = 200;
      tx_steady = 1'b1;
      for (n = 0; n < 4; n++)
         send_report(crd_pkg::REPORT_HEADER, crd_pkg::TYPE_ALL, 2, FILL_RANDOM);
      tx_steady = 1'b0;
      settle();
   endtask

   task automatic test_sender_pause();
      send_report(crd_pkg::REPORT_HEADER, crd_pkg::TYPE_ACC_EXT, 5, FILL_RANDOM);
      req_stop();
      while (field_expect_q.size() != 0) @(posedge clock);
      // back-to-back traffic with no idling on either side
      tx_steady  = 1'b1;
      rsp_steady = 1'b1;
      send_report(crd_pkg::REPORT_HEADER, crd_pkg::TYPE_ALL, 2, FILL_RANDOM);
      send_report(crd_pkg::REPORT_HEADER, crd_pkg::TYPE_BTN_21, 3, FILL_RANDOM);
      tx_steady  = 1'b0;
      rsp_steady = 1'b0;
   endtask

   task automatic test_random_reports();
      int unsigned   r, len;
      logic [7:0]    hdr, rtype;
      fill_mode_type fill;
      do begin
         if ($urandom_range(0, 3) == 0)
            set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         r = $urandom_range(0, 99);
         if (r < 80) begin
            // well-formed report, short to keep the byte count near target
            hdr   = crd_pkg::REPORT_HEADER;
            rtype = layout_type($urandom_range(0, 8));
            len   = $urandom_range(2, 10);
         end else begin
            hdr   = ($urandom_range(0, 1) == 1) ? crd_pkg::REPORT_HEADER : 8'($urandom);
            rtype = 8'($urandom);
            len   = $urandom_range(1, 6);
         end
         fill = ($urandom_range(0, 9) < 7) ? FILL_RANDOM : FILL_MIXED;
         send_report(hdr, rtype, len, fill);
      end while (bytes_sent < TOTAL_ITEMS);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_report_layouts();
      test_field_extremes();
      test_malformed_reports();
      test_config_sweep();
      test_output_backpressure();
      test_sender_pause();
      test_random_reports();
      settle();
      if (!mismatch_seen)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
